### hw/rtl/sisb_pkg.sv
// Shared types and constants for the sorted integer set bank.
// No dependencies; imported by the front end, back end and top level.
package sisb_pkg;

    // Opcode of one command
    typedef enum logic [3:0] {
        OP_CLEAR     = 4'd0,
        OP_ADD       = 4'd1,
        OP_REMOVE    = 4'd2,
        OP_CONTAINS  = 4'd3,
        OP_EQUAL     = 4'd4,
        OP_SUBSET    = 4'd5,
        OP_UNION     = 4'd6,
        OP_INTERSECT = 4'd7,
        OP_PRINT     = 4'd8
    } op_t;

    // Status codes of add and remove
    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_PRESENT  = 2'd1,
        STS_NOTFOUND = 2'd2,
        STS_FULL     = 2'd3
    } status_t;

    // Longest stream one command may produce
    localparam int MAX_RESULTS = 32;

    // Decoded command passed from front to back
    typedef struct packed {
        op_t                op;
        logic [2:0]         set_a;
        logic [2:0]         set_b;
        logic signed [31:0] element;
    } cmd_t;

endpackage

### hw/rtl/sisb_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module sisb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### hw/rtl/sisb_front.sv
// Front end: accepts input beats, drops unused opcodes, reduces set indexes
// and queues decoded commands for the back end. Depends on sisb_pkg.
module sisb_front
    import sisb_pkg::*;
#(
    parameter int NUM_SETS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [3:0]  s_tuser,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;
    cmd_t       dec;

    // Reduce a raw set index modulo the bank size
    function automatic logic [2:0] mod_set(input logic [2:0] v);
        logic [3:0] t;
        t = {1'b0, v};
        for (int k = 0; k < 4; k++)
        begin
            if (int'(t) >= NUM_SETS)
            begin
                t = t - 4'(NUM_SETS);
            end
        end
        return t[2:0];
    endfunction

    // Decode the incoming beat
    always_comb
    begin
        dec.op      = op_t'(s_tuser);
        dec.set_a   = mod_set(s_tdata[2:0]);
        dec.set_b   = mod_set(s_tdata[5:3]);
        dec.element = s_tdata[37:6];
    end

    assign s_tready  = (fill_reg != 2'd2);
    assign push      = s_tvalid && s_tready && (s_tuser <= OP_PRINT);
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // Advance queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

### hw/rtl/sisb_back.sv
// Back end: executes queued commands on the element RAM and per-set counts,
// and drives the result output register. Depends on sisb_pkg and sisb_ram.
module sisb_back
    import sisb_pkg::*;
#(
    parameter int NUM_SETS = 8,
    parameter int CAP      = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] out_value,
    output logic        out_answer,
    output logic [1:0]  out_status,
    output logic        out_empty,
    output logic        out_last
);

    localparam int SW    = $clog2(NUM_SETS);
    localparam int IW    = $clog2(CAP + 1);
    localparam int DEPTH = NUM_SETS * CAP;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_RESULTS + 1);

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_LDA  = 15'b000000000000010,
        ST_LDB  = 15'b000000000000100,
        ST_SRD  = 15'b000000000001000,
        ST_SEV  = 15'b000000000010000,
        ST_ACHK = 15'b000000000100000,
        ST_ARD  = 15'b000000001000000,
        ST_AEV  = 15'b000000010000000,
        ST_RCHK = 15'b000000100000000,
        ST_RRD  = 15'b000001000000000,
        ST_REV  = 15'b000010000000000,
        ST_MRD  = 15'b000100000000000,
        ST_MEV  = 15'b001000000000000,
        ST_FIN  = 15'b010000000000000,
        ST_SPARE = 15'b100000000000000
    } state_t;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [SW-1:0]      a_reg, a_next, b_reg, b_next;
    logic signed [31:0] e_reg, e_next;
    logic [IW-1:0]      na_reg, na_next, nb_reg, nb_next;
    logic [IW-1:0]      i_reg, i_next, j_reg, j_next;
    logic signed [31:0] pend_reg, pend_next;
    logic               pend_v_reg, pend_v_next;
    logic [RW-1:0]      cnt_reg, cnt_next;
    status_t            sts_reg, sts_next;
    logic               ans_reg, ans_next;
    logic [IW-1:0]      counts_reg [NUM_SETS];
    logic [IW-1:0]      counts_next [NUM_SETS];
    logic               ov_reg, ov_next;
    logic [31:0]        ovalue_reg;
    logic               oans_reg, oempty_reg, olast_reg;
    logic [1:0]         osts_reg;

    logic               we;
    logic [AW-1:0]      waddr, raddr_a, raddr_b, base_a, base_b;
    logic signed [31:0] wdata, qa, qb;
    logic [IW-1:0]      cnt_rd;
    logic               out_free;
    logic               load_o;
    logic [31:0]        o_value;
    logic               o_answer, o_empty, o_last;
    logic [1:0]         o_status;

    // Element storage
    sisb_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (qa),
        .raddr_b (raddr_b),
        .rdata_b (qb)
    );

    assign base_a   = AW'(a_reg) * AW'(CAP);
    assign base_b   = AW'(b_reg) * AW'(CAP);
    assign raddr_a  = base_a + AW'(i_reg);
    assign raddr_b  = base_b + AW'(j_reg);
    assign cnt_rd   = counts_reg[(state_reg == ST_LDA) ? a_reg : b_reg];
    assign out_free = !ov_reg || m_tready;

    // Sequence one command
    always_comb
    begin
        logic ea, eb, a_lt, b_lt, eqv, emit, adv_i, adv_j, fin;
        logic signed [31:0] ev;

        state_next  = state_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        e_next      = e_reg;
        na_next     = na_reg;
        nb_next     = nb_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        cnt_next    = cnt_reg;
        sts_next    = sts_reg;
        ans_next    = ans_reg;
        counts_next = counts_reg;
        cmd_ready   = 1'b0;
        we          = 1'b0;
        waddr       = base_a + AW'(j_reg);
        wdata       = e_reg;
        load_o      = 1'b0;
        o_value     = 32'd0;
        o_answer    = 1'b0;
        o_status    = STS_OK;
        o_empty     = 1'b0;
        o_last      = 1'b0;

        ea    = (i_reg < na_reg);
        eb    = (j_reg < nb_reg);
        a_lt  = (qa < qb);
        b_lt  = (qb < qa);
        eqv   = (qa == qb);
        emit  = 1'b0;
        adv_i = 1'b0;
        adv_j = 1'b0;
        fin   = 1'b0;
        ev    = qa;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_ready   = 1'b1;
                    op_next     = cmd.op;
                    a_next      = SW'(cmd.set_a);
                    b_next      = SW'(cmd.set_b);
                    e_next      = cmd.element;
                    i_next      = '0;
                    j_next      = '0;
                    pend_v_next = 1'b0;
                    cnt_next    = '0;
                    sts_next    = STS_OK;
                    ans_next    = 1'b0;
                    state_next  = ST_LDA;
                end
            end
            ST_LDA:
            begin
                na_next    = cnt_rd;
                state_next = ST_LDB;
            end
            ST_LDB:
            begin
                nb_next = cnt_rd;
                unique case (op_reg)
                    OP_CLEAR:
                    begin
                        counts_next[a_reg] = '0;
                        state_next         = ST_FIN;
                    end
                    OP_ADD, OP_REMOVE, OP_CONTAINS:
                    begin
                        state_next = ST_SRD;
                    end
                    OP_EQUAL:
                    begin
                        state_next = (na_reg != cnt_rd) ? ST_FIN : ST_MRD;
                    end
                    OP_PRINT:
                    begin
                        // print walks set_a alone through the union path
                        nb_next    = '0;
                        state_next = ST_MRD;
                    end
                    OP_SUBSET, OP_UNION, OP_INTERSECT:
                    begin
                        state_next = ST_MRD;
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_SRD:
            begin
                state_next = ST_SEV;
            end
            ST_SEV:
            begin
                if (!ea)
                begin
                    state_next = ST_FIN;
                    if (op_reg == OP_ADD)
                    begin
                        if (na_reg >= IW'(CAP))
                        begin
                            sts_next = STS_FULL;
                        end
                        else
                        begin
                            j_next     = na_reg;
                            state_next = ST_ACHK;
                        end
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        sts_next = STS_NOTFOUND;
                    end
                end
                else if (qa == e_reg)
                begin
                    state_next = ST_FIN;
                    if (op_reg == OP_ADD)
                    begin
                        sts_next = STS_PRESENT;
                    end
                    else if (op_reg == OP_REMOVE)
                    begin
                        state_next = ST_RCHK;
                    end
                    else
                    begin
                        ans_next = 1'b1;
                    end
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_SRD;
                end
            end
            ST_ACHK:
            begin
                if (j_reg == '0)
                begin
                    we                 = 1'b1;
                    counts_next[a_reg] = na_reg + IW'(1);
                    state_next         = ST_FIN;
                end
                else
                begin
                    i_next     = j_reg - IW'(1);
                    state_next = ST_ARD;
                end
            end
            ST_ARD:
            begin
                state_next = ST_AEV;
            end
            ST_AEV:
            begin
                we = 1'b1;
                if (e_reg < qa)
                begin
                    // shift the larger entry up one slot
                    wdata      = qa;
                    j_next     = j_reg - IW'(1);
                    state_next = ST_ACHK;
                end
                else
                begin
                    counts_next[a_reg] = na_reg + IW'(1);
                    state_next         = ST_FIN;
                end
            end
            ST_RCHK:
            begin
                if ((i_reg + IW'(1)) >= na_reg)
                begin
                    counts_next[a_reg] = na_reg - IW'(1);
                    state_next         = ST_FIN;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_RRD;
                end
            end
            ST_RRD:
            begin
                state_next = ST_REV;
            end
            ST_REV:
            begin
                // shift the next entry down one slot
                we         = 1'b1;
                waddr      = base_a + AW'(i_reg) - AW'(1);
                wdata      = qa;
                state_next = ST_RCHK;
            end
            ST_MRD:
            begin
                state_next = ST_MEV;
            end
            ST_MEV:
            begin
                unique case (op_reg)
                    OP_UNION, OP_PRINT:
                    begin
                        if (!ea && !eb)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            emit = 1'b1;
                            if (!eb || (ea && a_lt))
                            begin
                                ev    = qa;
                                adv_i = 1'b1;
                            end
                            else if (!ea || b_lt)
                            begin
                                ev    = qb;
                                adv_j = 1'b1;
                            end
                            else
                            begin
                                ev    = qa;
                                adv_i = 1'b1;
                                adv_j = 1'b1;
                            end
                        end
                    end
                    OP_INTERSECT:
                    begin
                        if (!ea || !eb)
                        begin
                            fin = 1'b1;
                        end
                        else if (eqv)
                        begin
                            emit  = 1'b1;
                            ev    = qa;
                            adv_i = 1'b1;
                            adv_j = 1'b1;
                        end
                        else if (a_lt)
                        begin
                            adv_i = 1'b1;
                        end
                        else
                        begin
                            adv_j = 1'b1;
                        end
                    end
                    OP_SUBSET:
                    begin
                        if (!eb)
                        begin
                            ans_next = 1'b1;
                            fin      = 1'b1;
                        end
                        else if (!ea || b_lt)
                        begin
                            fin = 1'b1;
                        end
                        else if (eqv)
                        begin
                            adv_i = 1'b1;
                            adv_j = 1'b1;
                        end
                        else
                        begin
                            adv_i = 1'b1;
                        end
                    end
                    default:
                    begin
                        // equal: counts already match
                        if (!ea)
                        begin
                            ans_next = 1'b1;
                            fin      = 1'b1;
                        end
                        else if (eqv)
                        begin
                            adv_i = 1'b1;
                            adv_j = 1'b1;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                endcase

                if (emit && pend_v_reg)
                begin
                    if (out_free)
                    begin
                        // send the held element, hold the new one
                        load_o    = 1'b1;
                        o_value   = pend_reg;
                        pend_next = ev;
                        cnt_next  = cnt_reg + RW'(1);
                        if ((cnt_reg + RW'(2)) == RW'(MAX_RESULTS))
                        begin
                            fin = 1'b1;
                        end
                    end
                    else
                    begin
                        adv_i = 1'b0;
                        adv_j = 1'b0;
                        fin   = 1'b0;
                        emit  = 1'b0;
                    end
                end
                else if (emit)
                begin
                    pend_next   = ev;
                    pend_v_next = 1'b1;
                end

                if (adv_i)
                begin
                    i_next = i_reg + IW'(1);
                end
                if (adv_j)
                begin
                    j_next = j_reg + IW'(1);
                end
                if (fin)
                begin
                    state_next = ST_FIN;
                end
                else if (adv_i || adv_j)
                begin
                    state_next = ST_MRD;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    load_o = 1'b1;
                    o_last = 1'b1;
                    if (op_reg == OP_UNION || op_reg == OP_INTERSECT ||
                        op_reg == OP_PRINT)
                    begin
                        o_value = pend_v_reg ? pend_reg : 32'd0;
                        o_empty = !pend_v_reg;
                    end
                    else
                    begin
                        o_answer = ans_reg;
                        o_status = sts_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        ov_next = load_o ? 1'b1 : (m_tready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ov_reg     <= 1'b0;
            pend_v_reg <= 1'b0;
            for (int k = 0; k < NUM_SETS; k++)
            begin
                counts_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            ov_reg     <= ov_next;
            pend_v_reg <= pend_v_next;
            counts_reg <= counts_next;
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        e_reg    <= e_next;
        na_reg   <= na_next;
        nb_reg   <= nb_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        pend_reg <= pend_next;
        cnt_reg  <= cnt_next;
        sts_reg  <= sts_next;
        ans_reg  <= ans_next;
        if (load_o)
        begin
            ovalue_reg <= o_value;
            oans_reg   <= o_answer;
            osts_reg   <= o_status;
            oempty_reg <= o_empty;
            olast_reg  <= o_last;
        end
    end

    assign m_tvalid   = ov_reg;
    assign out_value  = ovalue_reg;
    assign out_answer = oans_reg;
    assign out_status = osts_reg;
    assign out_empty  = oempty_reg;
    assign out_last   = olast_reg;

endmodule

### hw/rtl/sorted_integer_set_bank_core.sv
// Top level of the sorted integer set bank: front end, command queue and
// execution back end. Depends on sisb_pkg, sisb_front and sisb_back.
//
//   channel | dir | tdata                                   | tuser     | tlast
//   s_*     | in  | set_a, set_b, element                   | opcode    | -
//   m_*     | out | value, answer, status                   | empty_res | last
//
// The element RAM has a registered read, so a scan or merge step reads, then
// evaluates, and a shift step first checks the slot. Subset and equal walk both
// sets at most once. Reset empties every set at once through the count
// registers. The front queue keeps two commands while the back end stalls on a
// full output register. Unused opcodes are dropped without a result.
module sorted_integer_set_bank_core
    import sisb_pkg::*;
#(
    parameter int NUM_SETS = 8,
    parameter int CAP      = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // set_a[2:0], set_b[5:3], element[37:6], zero pad
    input  logic [3:0]  s_tuser,   // opcode[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // value[31:0], answer[32], status[34:33], zero pad
    output logic        m_tuser,   // empty_res
    output logic        m_tlast    // last
);

    cmd_t        cmd;
    logic        cmd_valid, cmd_ready;
    logic [31:0] value;
    logic        answer;
    logic [1:0]  status;

    sisb_front #(
        .NUM_SETS (NUM_SETS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    sisb_back #(
        .NUM_SETS (NUM_SETS),
        .CAP      (CAP)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_value  (value),
        .out_answer (answer),
        .out_status (status),
        .out_empty  (m_tuser),
        .out_last   (m_tlast)
    );

    // Pack the result beat
    assign m_tdata = {5'd0, status, answer, value};

endmodule

### bench/sorted_integer_set_bank_core_tb.sv
// Self-checking bench for the sorted integer set bank: a directed stimulus table, then
// random command sequences, each checked against a behavioral set bank model.
// Depends on sisb_pkg and the sorted_integer_set_bank_core RTL.
`timescale 1ns / 100ps

module sorted_integer_set_bank_core_tb;
    import sisb_pkg::*;

    localparam int NSETS = 8;
    localparam int SETCAP = 16;
    localparam int N_RANDOM = 220;

    typedef struct {
        logic [31:0] value;
        logic        answer;
        logic [1:0]  status;
        logic        empty_res;
        logic        last;
    } beat_t;

    // One directed row; has_exp marks rows whose result is typed in
    typedef struct {
        logic [3:0]  opcode;
        logic [2:0]  set_a;
        logic [2:0]  set_b;
        logic [31:0] element;
        bit          has_exp;
        logic        exp_answer;
        logic [1:0]  exp_status;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Model state of the bank
    logic signed [31:0] bank_elems [NSETS][SETCAP];
    int                 bank_count [NSETS];

    beat_t pending_beats[$];
    int    error_count;
    int    beat_count;
    int    stream_count;
    bit    stim_done;

    sorted_integer_set_bank_core #(.NUM_SETS(NSETS), .CAP(SETCAP)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    function automatic int find_elem(int s, logic signed [31:0] v);
        for (int j = 0; j < bank_count[s]; j++)
            if (bank_elems[s][j] == v)
                return j;
        return -1;
    endfunction

    function automatic beat_t flag_beat(logic answer, logic [1:0] status);
        beat_t b;
        b.value = '0;
        b.answer = answer;
        b.status = status;
        b.empty_res = 1'b0;
        b.last = 1'b1;
        return b;
    endfunction

    // Queue a sorted element stream, or one empty marker
    task automatic push_stream(logic signed [31:0] buf_q[$]);
        beat_t b;
        int    n;
        n = buf_q.size() > MAX_RESULTS ? MAX_RESULTS : buf_q.size();
        stream_count++;
        if (n == 0)
        begin
            b = flag_beat(1'b0, STS_OK);
            b.empty_res = 1'b1;
            pending_beats.push_back(b);
        end
        for (int j = 0; j < n; j++)
        begin
            b = flag_beat(1'b0, STS_OK);
            b.value = buf_q[j];
            b.last = (j + 1 == n);
            pending_beats.push_back(b);
        end
    endtask

    // Apply one command to the model bank and queue its expected beats
    task automatic predict_set_op(logic [3:0] opc, logic [2:0] sa, logic [2:0] sb,
                                  logic signed [31:0] e);
        int                 a;
        int                 b;
        int                 p;
        int                 i;
        int                 j;
        bit                 ok;
        logic signed [31:0] merged[$];
        a = sa % NSETS;
        b = sb % NSETS;
        case (opc)
            OP_CLEAR:
            begin
                bank_count[a] = 0;
                pending_beats.push_back(flag_beat(1'b0, STS_OK));
            end
            OP_ADD:
            begin
                if (find_elem(a, e) >= 0)
                    pending_beats.push_back(flag_beat(1'b0, STS_PRESENT));
                else if (bank_count[a] >= SETCAP)
                    pending_beats.push_back(flag_beat(1'b0, STS_FULL));
                else
                begin
                    j = bank_count[a];
                    while (j > 0 && e < bank_elems[a][j-1])
                    begin
                        bank_elems[a][j] = bank_elems[a][j-1];
                        j--;
                    end
                    bank_elems[a][j] = e;
                    bank_count[a]++;
                    pending_beats.push_back(flag_beat(1'b0, STS_OK));
                end
            end
            OP_REMOVE:
            begin
                p = find_elem(a, e);
                if (p < 0)
                    pending_beats.push_back(flag_beat(1'b0, STS_NOTFOUND));
                else
                begin
                    for (j = p; j + 1 < bank_count[a]; j++)
                        bank_elems[a][j] = bank_elems[a][j+1];
                    bank_count[a]--;
                    pending_beats.push_back(flag_beat(1'b0, STS_OK));
                end
            end
            OP_CONTAINS:
                pending_beats.push_back(flag_beat(find_elem(a, e) >= 0, STS_OK));
            OP_EQUAL:
            begin
                ok = bank_count[a] == bank_count[b];
                for (j = 0; ok && j < bank_count[a]; j++)
                    if (bank_elems[a][j] != bank_elems[b][j])
                        ok = 0;
                pending_beats.push_back(flag_beat(ok, STS_OK));
            end
            OP_SUBSET:
            begin
                ok = 1;
                for (j = 0; j < bank_count[b]; j++)
                    if (find_elem(a, bank_elems[b][j]) < 0)
                        ok = 0;
                pending_beats.push_back(flag_beat(ok, STS_OK));
            end
            OP_UNION:
            begin
                i = 0;
                j = 0;
                while (i < bank_count[a] || j < bank_count[b])
                begin
                    if (j >= bank_count[b] ||
                        (i < bank_count[a] && bank_elems[a][i] < bank_elems[b][j]))
                        merged.push_back(bank_elems[a][i++]);
                    else if (i >= bank_count[a] || bank_elems[b][j] < bank_elems[a][i])
                        merged.push_back(bank_elems[b][j++]);
                    else
                    begin
                        merged.push_back(bank_elems[a][i++]);
                        j++;
                    end
                end
                push_stream(merged);
            end
            OP_INTERSECT:
            begin
                for (i = 0; i < bank_count[a]; i++)
                    if (find_elem(b, bank_elems[a][i]) >= 0)
                        merged.push_back(bank_elems[a][i]);
                push_stream(merged);
            end
            OP_PRINT:
            begin
                for (i = 0; i < bank_count[a]; i++)
                    merged.push_back(bank_elems[a][i]);
                push_stream(merged);
            end
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
        $display("ERROR @%0t beat %0d: %s got %h want %h", $realtime, beat_count, what,
                 got, want);
        error_count++;
    endtask

    // Short random gap: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one command beat and wait for its acceptance
    task automatic send_cmd(logic [3:0] opc, logic [2:0] sa, logic [2:0] sb,
                            logic [31:0] e);
        int gap;
        gap = gap_len();
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= opc;
        s_tdata  <= {2'b00, e, sb, sa};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_set_op(opc, sa, sb, e);
    endtask

    // Element values: a narrow pool for collisions, extremes, and full range
    function automatic logic [31:0] pick_elem();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $signed($urandom_range(0, 40)) - 20;
        if (r == 6)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        return $urandom();
    endfunction

    // Drain the master side with random stalls and check every beat
    initial
    begin
        beat_t want;
        beat_t got;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.value = m_tdata[31:0];
                got.answer = m_tdata[32];
                got.status = m_tdata[34:33];
                got.empty_res = m_tuser;
                got.last = m_tlast;
                beat_count++;
                if (pending_beats.size() == 0)
                    report_mismatch("unexpected beat", m_tdata, '0);
                else
                begin
                    want = pending_beats.pop_front();
                    if (got.value !== want.value)
                        report_mismatch("value", 40'(got.value), 40'(want.value));
                    if (got.answer !== want.answer)
                        report_mismatch("answer", 40'(got.answer), 40'(want.answer));
                    if (got.status !== want.status)
                        report_mismatch("status", 40'(got.status), 40'(want.status));
                    if (got.empty_res !== want.empty_res)
                        report_mismatch("empty_res", 40'(got.empty_res),
                                        40'(want.empty_res));
                    if (got.last !== want.last)
                        report_mismatch("last", 40'(got.last), 40'(want.last));
                    if (m_tdata[39:35] !== '0)
                        report_mismatch("tdata pad", m_tdata, '0);
                end
            end
            // full throughput for the first 40 result beats, random stalls after that
            m_tready <= (beat_count < 40) ? 1'b1 : (gap_len() == 0);
        end
    end

    // Directed table, then random command sequences
    initial
    begin
        row_t               dir_rows[$];
        beat_t              want;
        int                 r;
        logic [3:0]         opc;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        error_count = 0;
        beat_count = 0;
        stream_count = 0;
        stim_done = 0;
        for (int s = 0; s < NSETS; s++)
            bank_count[s] = 0;

        // opcode, set_a, set_b, element, typed result?, answer, status
        dir_rows = '{
            '{OP_PRINT,     3'd0, 3'd0, 32'd0,        0, 1'b0, STS_OK},
            '{OP_CONTAINS,  3'd7, 3'd0, 32'd5,        1, 1'b0, STS_OK},
            '{OP_REMOVE,    3'd1, 3'd0, 32'd5,        1, 1'b0, STS_NOTFOUND},
            '{OP_EQUAL,     3'd2, 3'd3, 32'd0,        1, 1'b1, STS_OK},
            '{OP_SUBSET,    3'd2, 3'd3, 32'd0,        1, 1'b1, STS_OK},
            '{OP_ADD,       3'd0, 3'd0, 32'h8000_0000, 1, 1'b0, STS_OK},
            '{OP_ADD,       3'd0, 3'd0, 32'h7fff_ffff, 1, 1'b0, STS_OK},
            '{OP_ADD,       3'd0, 3'd0, 32'hffff_ffff, 1, 1'b0, STS_OK},
            '{OP_ADD,       3'd0, 3'd0, 32'd0,        1, 1'b0, STS_OK},
            '{OP_ADD,       3'd0, 3'd0, 32'h7fff_ffff, 1, 1'b0, STS_PRESENT},
            '{OP_ADD,       3'd7, 3'd0, 32'd0,        1, 1'b0, STS_OK},
            '{OP_PRINT,     3'd0, 3'd0, 32'd0,        0, 1'b0, STS_OK},
            '{OP_CONTAINS,  3'd0, 3'd0, 32'h8000_0000, 1, 1'b1, STS_OK},
            '{4'd9,         3'd0, 3'd0, 32'd0,        0, 1'b0, STS_OK},
            '{4'd15,        3'd5, 3'd5, 32'hffff_ffff, 0, 1'b0, STS_OK},
            '{OP_SUBSET,    3'd0, 3'd7, 32'd0,        1, 1'b1, STS_OK},
            '{OP_SUBSET,    3'd7, 3'd0, 32'd0,        1, 1'b0, STS_OK},
            '{OP_EQUAL,     3'd0, 3'd7, 32'd0,        1, 1'b0, STS_OK},
            '{OP_UNION,     3'd0, 3'd7, 32'd0,        0, 1'b0, STS_OK},
            '{OP_INTERSECT, 3'd0, 3'd7, 32'd0,        0, 1'b0, STS_OK},
            '{OP_INTERSECT, 3'd1, 3'd0, 32'd0,        0, 1'b0, STS_OK},
            '{OP_REMOVE,    3'd0, 3'd0, 32'h8000_0000, 1, 1'b0, STS_OK},
            '{OP_CLEAR,     3'd7, 3'd0, 32'd0,        1, 1'b0, STS_OK},
            '{OP_PRINT,     3'd7, 3'd0, 32'd0,        0, 1'b0, STS_OK}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            send_cmd(dir_rows[k].opcode, dir_rows[k].set_a, dir_rows[k].set_b,
                     dir_rows[k].element);
            // typed-in rows overwrite the model's expectation to pin it down
            if (dir_rows[k].has_exp)
            begin
                want = flag_beat(dir_rows[k].exp_answer, dir_rows[k].exp_status);
                pending_beats[pending_beats.size() - 1] = want;
            end
        end

        // fill set 3 to capacity, then add to the full set: full and present
        for (int v = 0; v < SETCAP; v++)
            send_cmd(OP_ADD, 3'd3, 3'd0, 32'(SETCAP - 1 - v) * 32'd3 - 32'd20);
        send_cmd(OP_ADD, 3'd3, 3'd0, 32'd2);
        send_cmd(OP_ADD, 3'd3, 3'd0, 32'hffff_ffec);
        // hold off until every expected beat has drained
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);

        // random: adds and removes build sets, mixed with clears, queries and unused opcodes
        for (int k = 0; k < N_RANDOM; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                opc = OP_ADD;
            else if (r < 45)
                opc = OP_REMOVE;
            else if (r < 50)
                opc = OP_CLEAR;
            else if (r < 96)
                opc = 4'($urandom_range(OP_CONTAINS, OP_PRINT));
            else
                opc = 4'($urandom_range(9, 15));
            send_cmd(opc, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                     pick_elem());
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    // Finish once all beats have drained plus a latency margin
    initial
    begin
        wait (stim_done);
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered %0d result beats, %0d element streams, all opcodes and full sets.",
                 beat_count, stream_count);
        if (error_count == 0 && pending_beats.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout with %0d beats outstanding", pending_beats.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
